[rtl/core/vsir_pkg.sv]
package vsir_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int CHANNEL_COUNT = 2;
  localparam int CH_BITS       = 1;
  localparam int PHASE_BITS    = FRACTION_BITS + 2;
  localparam int MAX_RESULTS   = 10;
  localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);
  // accumulator wide enough for the cubic intermediate terms
  localparam int ACC_BITS      = SAMPLE_BITS + 5;
  localparam int PROD_BITS     = ACC_BITS + FRACTION_BITS + 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = PHASE_BITS;
  localparam int MODE_BITS     = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_STEP  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTERP_MODE = 1'd1;

  localparam logic [MODE_BITS-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LINEAR  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CUBIC   = 2'd2;

  localparam logic [PHASE_BITS-1:0] PH_ONE        = PHASE_BITS'(1) << FRACTION_BITS;
  localparam logic [PHASE_BITS-1:0] PH_START      = PHASE_BITS'(2) << FRACTION_BITS;
  localparam logic [PHASE_BITS-1:0] STEP_RESET    = PH_ONE;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [CH_BITS-1:0]            in_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic [CH_BITS-1:0]            out_channel;
    logic                          last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FIN,
    ST_EMIT
  } back_state_t;

endpackage

[rtl/core/vsir_front.sv]
module vsir_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  vsir_pkg::in_item_t in_item,
  output logic               in_full,
  output vsir_pkg::in_item_t fq_item,
  output logic               fq_valid,
  input  logic               bk_pop
);
  import vsir_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  in_item_t              mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_BITS:0]     cnt_r, cnt_nxt;
  logic                  accept, wr_en, rd_en;

  assign in_full  = (cnt_r == (PTR_BITS + 1)'(QUEUE_DEPTH));
  assign fq_valid = (cnt_r != '0);
  assign fq_item  = mem_r[rd_ptr_r];

  // items for a channel outside the configured set are dropped here
  assign accept = in_push && !in_full;
  assign wr_en  = accept && (int'(in_item.in_channel) < CHANNEL_COUNT);
  assign rd_en  = bk_pop && fq_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? PTR_BITS'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? PTR_BITS'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

[rtl/core/vsir_back.sv]
module vsir_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vsir_pkg::in_item_t                  fq_item,
  input  logic                                fq_valid,
  output logic                                bk_pop,
  output vsir_pkg::out_item_t                 bk_item,
  output logic                                bk_push,
  input  logic                                oq_full,
  input  logic [vsir_pkg::PHASE_BITS-1:0]     speed_step,
  input  logic [vsir_pkg::MODE_BITS-1:0]      interp_mode
);
  import vsir_pkg::*;

  localparam int MW = ACC_BITS;
  localparam int PW = PROD_BITS;
  localparam logic signed [PW:0] HALF_A = (PW + 1)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [PW:0] HALF_B = (PW + 1)'(1) << FRACTION_BITS;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_acc(input logic signed [MW-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v[MW-1:SAMPLE_BITS-1] == '0 || v[MW-1:SAMPLE_BITS-1] == '1) begin
      r = v[SAMPLE_BITS-1:0];
    end else if (v[MW-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  back_state_t st_r, st_nxt;

  logic signed [SAMPLE_BITS-1:0] hist_r  [CHANNEL_COUNT][4];
  logic [PHASE_BITS-1:0]         phase_r [CHANNEL_COUNT];

  logic signed [SAMPLE_BITS-1:0] win_r [4];
  logic signed [SAMPLE_BITS-1:0] win_nxt [4];
  logic [PHASE_BITS-1:0]         ph_r, ph_nxt;
  logic [CNT_BITS-1:0]           cnt_r, cnt_nxt;
  logic [CH_BITS-1:0]            ch_r, ch_nxt;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r, res_nxt;

  logic                          hist_we, phase_we;
  logic [PHASE_BITS-1:0]         phase_wb, ph_adv;
  logic [PHASE_BITS:0]           ph_sum;
  logic                          run_more, last;

  logic signed [MW-1:0]          e0, e1, e2, e3;
  logic signed [MW-1:0]          s1, c2, mop, lin_sum, cub_sum;
  logic signed [MW-1:0]          r16, r17;
  logic signed [PW:0]            rnd_a, rnd_b;
  logic signed [FRACTION_BITS:0] xs;

  assign e0 = MW'(win_r[0]);
  assign e1 = MW'(win_r[1]);
  assign e2 = MW'(win_r[2]);
  assign e3 = MW'(win_r[3]);
  assign s1 = MW'(3 * (e1 - e2) + e3 - e0);
  assign c2 = MW'(2 * e0 - 5 * e1 + 4 * e2 - e3);

  // floor((p + half) / 2^s), taken as bit slices of the rounded product
  assign rnd_a = {prod_r[PW-1], prod_r} + HALF_A;
  assign rnd_b = {prod_r[PW-1], prod_r} + HALF_B;
  assign r16   = rnd_a[FRACTION_BITS +: MW];
  assign r17   = rnd_b[FRACTION_BITS + 1 +: MW];

  assign xs      = {1'b0, ph_r[FRACTION_BITS-1:0]};
  assign lin_sum = e1 + r16;
  assign cub_sum = e1 + r17;

  assign ph_sum   = {1'b0, ph_r} + {1'b0, speed_step};
  assign ph_adv   = ph_sum[PHASE_BITS] ? '1 : ph_sum[PHASE_BITS-1:0];
  assign run_more = (ph_r < PH_ONE) && (cnt_r < CNT_BITS'(MAX_RESULTS));
  assign last     = (ph_adv >= PH_ONE) || (cnt_r == CNT_BITS'(MAX_RESULTS - 1));
  assign phase_wb = (ph_r >= PH_ONE) ? (ph_r - PH_ONE) : '0;

  assign bk_item.out_sample  = res_r;
  assign bk_item.out_channel = ch_r;
  assign bk_item.last_of_run = last;

  always_comb begin
    st_nxt   = st_r;
    win_nxt  = win_r;
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    ch_nxt   = ch_r;
    res_nxt  = res_r;
    mop      = s1;
    bk_pop   = 1'b0;
    bk_push  = 1'b0;
    hist_we  = 1'b0;
    phase_we = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (fq_valid) begin
          bk_pop     = 1'b1;
          hist_we    = 1'b1;
          win_nxt[0] = hist_r[fq_item.in_channel][1];
          win_nxt[1] = hist_r[fq_item.in_channel][2];
          win_nxt[2] = hist_r[fq_item.in_channel][3];
          win_nxt[3] = fq_item.in_sample;
          ph_nxt     = phase_r[fq_item.in_channel];
          ch_nxt     = fq_item.in_channel;
          cnt_nxt    = '0;
          st_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (run_more) begin
          if (interp_mode == MODE_NEAREST) begin
            st_nxt = ST_FIN;
          end else begin
            st_nxt = ST_MUL1;
          end
        end else begin
          phase_we = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      ST_MUL1: begin
        if (interp_mode == MODE_LINEAR) begin
          mop    = e2 - e1;
          st_nxt = ST_FIN;
        end else begin
          mop    = s1;
          st_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        mop    = c2 + r16;
        st_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        mop    = (e2 - e0) + r16;
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        case (interp_mode)
          MODE_NEAREST: res_nxt = ph_r[FRACTION_BITS-1] ? win_r[2] : win_r[1];
          MODE_LINEAR:  res_nxt = sat_acc(lin_sum);
          default:      res_nxt = sat_acc(cub_sum);
        endcase
        st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!oq_full) begin
          bk_push = 1'b1;
          ph_nxt  = ph_adv;
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = ST_CHECK;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign prod_nxt = PW'(xs) * PW'(mop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        phase_r[c] <= PH_START;
        for (int k = 0; k < 4; k++) begin
          hist_r[c][k] <= '0;
        end
      end
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (hist_we) begin
        for (int k = 0; k < 4; k++) begin
          hist_r[fq_item.in_channel][k] <= win_nxt[k];
        end
      end
      if (phase_we) begin
        phase_r[ch_r] <= phase_wb;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    ph_r   <= ph_nxt;
    ch_r   <= ch_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

endmodule

[rtl/core/vsir_out_q.sv]
module vsir_out_q (
  input  logic                clk,
  input  logic                rst_n,
  input  vsir_pkg::out_item_t bk_item,
  input  logic                bk_push,
  output logic                oq_full,
  output vsir_pkg::out_item_t out_item,
  output logic                out_empty,
  input  logic                out_pop
);
  import vsir_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  out_item_t             mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_BITS:0]     cnt_r, cnt_nxt;
  logic                  wr_en, rd_en;

  assign oq_full   = (cnt_r == (PTR_BITS + 1)'(QUEUE_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign wr_en     = bk_push && !oq_full;
  assign rd_en     = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = wr_en ? PTR_BITS'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? PTR_BITS'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= bk_item;
    end
  end

endmodule

[rtl/core/variable_speed_interpolating_resampler.sv]
// Channel   Ports                          Transfer
// input     in_push, in_full, in_item      push && !full
// result    out_pop, out_empty, out_item   pop && !empty
// config    cfg_we, cfg_idx, cfg_wdata     we high, no wait
//
// Each item is loaded into its window at idle and closed by a final check; per
// result the back end runs check, finish and emit, adding the first multiply step
// (linear) or the Horner steps in turn (cubic) on its single shared multiplier.
// Synchronous active-low reset: history zero, read position at start, queues empty.
// A two-entry item queue sits in front of the back end, a two-entry result
// queue behind it; a full result queue holds the back end in its emit step.
module variable_speed_interpolating_resampler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  vsir_pkg::in_item_t                   in_item,
  output logic                                 in_full,
  output vsir_pkg::out_item_t                  out_item,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  input  logic                                 cfg_we,
  input  logic [vsir_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [vsir_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import vsir_pkg::*;

  logic [PHASE_BITS-1:0] speed_step_r;
  logic [MODE_BITS-1:0]  interp_mode_r;

  in_item_t  fq_item;
  logic      fq_valid, bk_pop;
  out_item_t bk_item;
  logic      bk_push, oq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_step_r  <= STEP_RESET;
      interp_mode_r <= MODE_CUBIC;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SPEED_STEP:  speed_step_r  <= cfg_wdata[PHASE_BITS-1:0];
        REG_INTERP_MODE: interp_mode_r <= cfg_wdata[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  vsir_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .fq_item  (fq_item),
    .fq_valid (fq_valid),
    .bk_pop   (bk_pop)
  );

  vsir_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fq_item     (fq_item),
    .fq_valid    (fq_valid),
    .bk_pop      (bk_pop),
    .bk_item     (bk_item),
    .bk_push     (bk_push),
    .oq_full     (oq_full),
    .speed_step  (speed_step_r),
    .interp_mode (interp_mode_r)
  );

  vsir_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .bk_item   (bk_item),
    .bk_push   (bk_push),
    .oq_full   (oq_full),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    bk_push |-> !oq_full)
    else $error("result pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> fq_valid)
    else $error("back end took an item from an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

endmodule
